// File: hw/rtl/lkvc_pkg.sv
package lkvc_pkg;

  // Operation codes carried in the input item's tuser field.
  localparam int unsigned OP_W = 3;
  localparam logic [OP_W-1:0] OP_GET    = 3'd0;
  localparam logic [OP_W-1:0] OP_PUT    = 3'd1;
  localparam logic [OP_W-1:0] OP_ERASE  = 3'd2;
  localparam logic [OP_W-1:0] OP_EXISTS = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  // Capacity register.
  localparam int unsigned CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

endpackage

// File: hw/rtl/lru_key_value_cache.sv
// The block takes one item at a time: it accepts no new item until the previous result has been
// loaded into the output register, and each item waits for a scan of the key memory, which
// reads one entry per cycle through its single read port.
// Reset (rst_ni low, asynchronous): the table is empty, all recency ranks are zero,
// the capacity register holds 16 and no result is pending. Key and value memories are not cleared.
module lru_key_value_cache
  import lkvc_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned KEY_WIDTH   = 32,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration: capacity_limit.
  input  logic                 cfg_we_i,
  input  logic [CAP_W-1:0]     cfg_wdata_i,
  // Input items.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // tdata fields from bit 0: lookup_key, write_value, zero fill to whole bytes.
  input  logic [((KEY_WIDTH+VALUE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // tuser fields from bit 0: opcode.
  input  logic [OP_W-1:0]      s_axis_tuser,
  // Result items.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // tdata fields from bit 0: found, read_value, entry_count, zero fill to whole bytes.
  output logic [((1+VALUE_WIDTH+$clog2(MAX_ENTRIES+1)+7)/8)*8-1:0] m_axis_tdata
);

  localparam int unsigned IdxW   = $clog2(MAX_ENTRIES);
  localparam int unsigned CountW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned ScanW  = IdxW + 1;
  localparam int unsigned CmpW   = (CountW > CAP_W) ? CountW : CAP_W;
  localparam int unsigned OutW   = ((1 + VALUE_WIDTH + CountW + 7) / 8) * 8;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [OP_W-1:0]        op_q;
  logic [KEY_WIDTH-1:0]   key_q;
  logic [VALUE_WIDTH-1:0] val_q;
  logic [CAP_W-1:0]       cap_q;

  logic [ScanW-1:0]       addr_q;
  logic                   cmp_v_q;
  logic [IdxW-1:0]        cmp_idx_q;
  logic                   hit_q, free_q;
  logic [IdxW-1:0]        hit_idx_q, free_idx_q, lru1_idx_q, lru2_idx_q;

  logic [MAX_ENTRIES-1:0] valid_q, valid_d;
  logic [IdxW-1:0]        rank_q [MAX_ENTRIES];
  logic [IdxW-1:0]        rank_d [MAX_ENTRIES];
  logic [CountW-1:0]      count_q, count_d;

  logic                   m_valid_q;
  logic                   m_found_q;
  logic [VALUE_WIDTH-1:0] m_value_q;
  logic [CountW-1:0]      m_count_q;

  logic                   accept;
  logic                   scan_last;
  logic                   out_load;
  logic [CmpW-1:0]        cap_ext, cap_eff;
  logic                   full;
  logic [IdxW-1:0]        hit_rank;
  logic [IdxW-1:0]        slot;
  logic [IdxW-1:0]        victim;
  logic [CountW-1:0]      ins_count;
  logic                   evict;
  logic [CountW-1:0]      cnt_m1, cnt_m2;

  logic [IdxW-1:0]        key_raddr;
  logic [KEY_WIDTH-1:0]   key_rdata;
  logic [VALUE_WIDTH-1:0] val_rdata;
  logic                   key_we, val_we;
  logic [IdxW-1:0]        mem_waddr;

  logic                   res_found;
  logic [VALUE_WIDTH-1:0] res_value;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign scan_last     = cmp_v_q && (cmp_idx_q == IdxW'(MAX_ENTRIES - 1));
  assign out_load      = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready);

  // Capacity as used: zero acts as one, values above the table size saturate.
  assign cap_ext = CmpW'(cap_q);
  always_comb begin
    if (cap_ext == '0) begin
      cap_eff = CmpW'(1);
    end else if (cap_ext > CmpW'(MAX_ENTRIES)) begin
      cap_eff = CmpW'(MAX_ENTRIES);
    end else begin
      cap_eff = cap_ext;
    end
  end

  // Ranks of the two least recent entries, for the scan to locate them.
  assign cnt_m1 = count_q - CountW'(1);
  assign cnt_m2 = count_q - CountW'(2);

  // Insert decisions. A physically full table reuses the least recent slot,
  // and the entry that then becomes least recent is the one ranked second to last.
  assign full      = (count_q == CountW'(MAX_ENTRIES));
  assign hit_rank  = rank_q[hit_idx_q];
  assign slot      = full ? lru1_idx_q : free_idx_q;
  assign victim    = full ? lru2_idx_q : lru1_idx_q;
  assign ins_count = full ? count_q : count_q + CountW'(1);
  assign evict     = (CmpW'(ins_count) > cap_eff);

  // Key memory is scanned in address order; value memory is read at the hit.
  assign key_raddr = (addr_q < ScanW'(MAX_ENTRIES)) ? addr_q[IdxW-1:0] : '0;

  lkvc_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (MAX_ENTRIES)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (mem_waddr),
    .wdata_i (key_q),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata)
  );

  lkvc_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (MAX_ENTRIES)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (mem_waddr),
    .wdata_i (val_q),
    .raddr_i (hit_idx_q),
    .rdata_o (val_rdata)
  );

  // Table update for the current item, applied in the execute cycle.
  always_comb begin
    valid_d   = valid_q;
    rank_d    = rank_q;
    count_d   = count_q;
    key_we    = 1'b0;
    val_we    = 1'b0;
    mem_waddr = slot;
    if (state_q == ST_EXEC) begin
      case (op_q)
        OP_GET: begin
          if (hit_q) begin
            for (int j = 0; j < MAX_ENTRIES; j++) begin
              if (valid_q[j] && (rank_q[j] < hit_rank)) begin
                rank_d[j] = rank_q[j] + IdxW'(1);
              end
            end
            rank_d[hit_idx_q] = '0;
          end
        end
        OP_PUT: begin
          if (hit_q) begin
            val_we    = 1'b1;
            mem_waddr = hit_idx_q;
            for (int j = 0; j < MAX_ENTRIES; j++) begin
              if (valid_q[j] && (rank_q[j] < hit_rank)) begin
                rank_d[j] = rank_q[j] + IdxW'(1);
              end
            end
            rank_d[hit_idx_q] = '0;
          end else begin
            key_we = 1'b1;
            val_we = 1'b1;
            for (int j = 0; j < MAX_ENTRIES; j++) begin
              if (valid_q[j]) begin
                rank_d[j] = rank_q[j] + IdxW'(1);
              end
            end
            valid_d[slot] = 1'b1;
            rank_d[slot]  = '0;
            count_d       = ins_count;
            if (evict) begin
              valid_d[victim] = 1'b0;
              rank_d[victim]  = '0;
              count_d         = ins_count - CountW'(1);
            end
          end
        end
        OP_ERASE: begin
          if (hit_q) begin
            for (int j = 0; j < MAX_ENTRIES; j++) begin
              if (valid_q[j] && (rank_q[j] > hit_rank)) begin
                rank_d[j] = rank_q[j] - IdxW'(1);
              end
            end
            valid_d[hit_idx_q] = 1'b0;
            rank_d[hit_idx_q]  = '0;
            count_d            = count_q - CountW'(1);
          end
        end
        OP_CLEAR: begin
          valid_d = '0;
          for (int j = 0; j < MAX_ENTRIES; j++) begin
            rank_d[j] = '0;
          end
          count_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Sequencer: idle, scan of all entries, execute, then hand over the result.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers, scan bookkeeping and table state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cap_q   <= CAP_RESET;
      addr_q  <= '0;
      cmp_v_q <= 1'b0;
      hit_q   <= 1'b0;
      free_q  <= 1'b0;
      valid_q <= '0;
      count_q <= '0;
      for (int j = 0; j < MAX_ENTRIES; j++) begin
        rank_q[j] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (accept) begin
        addr_q  <= '0;
        cmp_v_q <= 1'b0;
        hit_q   <= 1'b0;
        free_q  <= 1'b0;
      end else if (state_q == ST_SCAN) begin
        if (addr_q < ScanW'(MAX_ENTRIES)) begin
          addr_q <= addr_q + ScanW'(1);
        end
        cmp_v_q <= (addr_q < ScanW'(MAX_ENTRIES));
        if (cmp_v_q && !valid_q[cmp_idx_q] && !free_q) begin
          free_q <= 1'b1;
        end
        if (cmp_v_q && valid_q[cmp_idx_q] && !hit_q && (key_rdata == key_q)) begin
          hit_q <= 1'b1;
        end
      end else begin
        cmp_v_q <= 1'b0;
      end
      if (state_q == ST_EXEC) begin
        valid_q <= valid_d;
        rank_q  <= rank_d;
        count_q <= count_d;
      end
    end
  end

  // Item fields and the entry indexes found by the scan.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= s_axis_tuser;
      key_q <= s_axis_tdata[KEY_WIDTH-1:0];
      val_q <= s_axis_tdata[KEY_WIDTH+VALUE_WIDTH-1:KEY_WIDTH];
    end
    if (state_q == ST_SCAN) begin
      cmp_idx_q <= addr_q[IdxW-1:0];
      if (cmp_v_q) begin
        if (valid_q[cmp_idx_q]) begin
          if (!hit_q && (key_rdata == key_q)) begin
            hit_idx_q <= cmp_idx_q;
          end
          if (rank_q[cmp_idx_q] == cnt_m1[IdxW-1:0]) begin
            lru1_idx_q <= cmp_idx_q;
          end
          if (rank_q[cmp_idx_q] == cnt_m2[IdxW-1:0]) begin
            lru2_idx_q <= cmp_idx_q;
          end
        end else if (!free_q) begin
          free_idx_q <= cmp_idx_q;
        end
      end
    end
  end

  // Result fields; only valid operations on a present key report found.
  assign res_found = hit_q && (op_q < OP_CLEAR);
  assign res_value = (hit_q && (op_q == OP_GET)) ? val_rdata : '0;

  // Output register, loaded once the previous result has been taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_found_q <= res_found;
      m_value_q <= res_value;
      m_count_q <= count_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OutW'({m_count_q, m_value_q, m_found_q});

endmodule

// File: hw/rtl/lkvc_ram.sv
module lkvc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/lkvc_checker.sv
module lkvc_checker #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned OUT_W       = 40
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  localparam int unsigned CountW = $clog2(MAX_ENTRIES + 1);

  logic                   out_found;
  logic [VALUE_WIDTH-1:0] out_value;
  logic [CountW-1:0]      out_count;

  assign out_found = m_axis_tdata[0];
  assign out_value = m_axis_tdata[VALUE_WIDTH:1];
  assign out_count = m_axis_tdata[VALUE_WIDTH+CountW:VALUE_WIDTH+1];

  // A stalled result holds its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // An accepted item keeps the block busy for the scan that follows.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item accepted while the previous one is in progress");

  // The entry count never exceeds the table size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> out_count <= CountW'(MAX_ENTRIES))
    else $error("entry count above table size");

  // A value is only returned for a key that was present.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !out_found |-> out_value == '0)
    else $error("value returned on a miss");

endmodule

bind lru_key_value_cache lkvc_checker #(
  .MAX_ENTRIES (MAX_ENTRIES),
  .VALUE_WIDTH (VALUE_WIDTH),
  .OUT_W       (OutW)
) u_lkvc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: verif/tb.sv
module tb;
  import lkvc_pkg::*;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned COUNT_W     = 5;
  localparam int unsigned REQ_W       = ((KEY_W + VALUE_W + 7) / 8) * 8;
  localparam int unsigned REPLY_W     = ((1 + VALUE_W + COUNT_W + 7) / 8) * 8;
  localparam int unsigned ITEMS_PER_PHASE = 88;
  localparam int unsigned KEY_POOL    = 20;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 25;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [VALUE_W-1:0] value;
    logic               found;
  } reply_t;

  // Shadow copy of the cache: predicts each reply and checks the block's output.
  class lru_cache_shadow;
    logic [KEY_W-1:0]   keys   [TABLE_DEPTH];
    logic [VALUE_W-1:0] values [TABLE_DEPTH];
    bit                 valid  [TABLE_DEPTH];
    int unsigned        rank   [TABLE_DEPTH];
    int unsigned        count;
    logic [CAP_W-1:0]   capacity;
    reply_t             expected_replies[$];
    int unsigned        errors;

    function new();
      for (int j = 0; j < TABLE_DEPTH; j++) begin
        valid[j] = 1'b0;
        rank[j]  = 0;
      end
      count    = 0;
      capacity = CAP_RESET;
      errors   = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] cap);
      capacity = cap;
    endfunction

    function int unsigned pending();
      return expected_replies.size();
    endfunction

    // Entries more recent than e age by one; e becomes rank zero.
    function void promote(int e);
      int unsigned r;
      r = rank[e];
      for (int j = 0; j < TABLE_DEPTH; j++) begin
        if (valid[j] && rank[j] < r) rank[j]++;
      end
      rank[e] = 0;
    endfunction

    // Entries older than e close the gap it leaves.
    function void drop_entry(int e);
      int unsigned r;
      r = rank[e];
      valid[e] = 1'b0;
      rank[e]  = 0;
      for (int j = 0; j < TABLE_DEPTH; j++) begin
        if (valid[j] && rank[j] > r) rank[j]--;
      end
      if (count > 0) count--;
    endfunction

    function void evict_oldest();
      int pick;
      pick = -1;
      for (int j = 0; j < TABLE_DEPTH; j++) begin
        if (valid[j] && (pick < 0 || rank[j] > rank[pick])) pick = j;
      end
      if (pick >= 0) drop_entry(pick);
    endfunction

    function int first_free();
      for (int j = 0; j < TABLE_DEPTH; j++) begin
        if (!valid[j]) return j;
      end
      return -1;
    endfunction

    // Applies one accepted request to the shadow table and queues its reply.
    function void note_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                               logic [VALUE_W-1:0] val);
      int          hit;
      int          slot;
      int unsigned cap;
      reply_t      r;
      cap = capacity;
      if (cap == 0) cap = 1;
      if (cap > TABLE_DEPTH) cap = TABLE_DEPTH;
      r = '0;
      if (op == OP_CLEAR) begin
        for (int j = 0; j < TABLE_DEPTH; j++) begin
          valid[j] = 1'b0;
          rank[j]  = 0;
        end
        count = 0;
      end else if (op <= OP_EXISTS) begin
        hit = -1;
        for (int j = 0; j < TABLE_DEPTH; j++) begin
          if (hit < 0 && valid[j] && keys[j] == key) hit = j;
        end
        r.found = (hit >= 0);
        case (op)
          OP_GET: begin
            if (hit >= 0) begin
              r.value = values[hit];
              promote(hit);
            end
          end
          OP_PUT: begin
            if (hit >= 0) begin
              values[hit] = val;
              promote(hit);
            end else begin
              // A physically full table gives up its oldest entry first.
              if (first_free() < 0) evict_oldest();
              slot = first_free();
              for (int j = 0; j < TABLE_DEPTH; j++) begin
                if (valid[j]) rank[j]++;
              end
              keys[slot]   = key;
              values[slot] = val;
              valid[slot]  = 1'b1;
              rank[slot]   = 0;
              count++;
              // Over capacity: exactly one eviction, even if still above the limit.
              if (count > cap && count > 1) evict_oldest();
            end
          end
          OP_ERASE: begin
            if (hit >= 0) drop_entry(hit);
          end
          default: begin
          end
        endcase
      end
      r.count = count[COUNT_W-1:0];
      expected_replies.push_back(r);
    endfunction

    // Compares one accepted reply with the oldest prediction.
    function void check_reply(reply_t got);
      reply_t want;
      if (expected_replies.size() == 0) begin
        $error("unexpected reply: found %0d, read_value %h, entry_count %0d",
               got.found, got.value, got.count);
        errors++;
        return;
      end
      want = expected_replies.pop_front();
      if (got.found !== want.found) begin
        $error("found: expected %0d, actual %0d", want.found, got.found);
        errors++;
      end
      if (got.value !== want.value) begin
        $error("read_value: expected %h, actual %h", want.value, got.value);
        errors++;
      end
      if (got.count !== want.count) begin
        $error("entry_count: expected %0d, actual %0d", want.count, got.count);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CAP_W-1:0]   cfg_wdata_i;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [REQ_W-1:0]   s_axis_tdata;
  logic [OP_W-1:0]    s_axis_tuser;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [REPLY_W-1:0] m_axis_tdata;

  lru_cache_shadow    shadow;
  int unsigned        gap_pct;
  int unsigned        stall_pct;
  logic [KEY_W-1:0]   key_pool [KEY_POOL];

  lru_key_value_cache #(
    .MAX_ENTRIES(TABLE_DEPTH),
    .KEY_WIDTH  (KEY_W),
    .VALUE_WIDTH(VALUE_W)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side: random stalls chosen at each falling edge.
  always @(negedge clk_i) begin
    m_axis_tready = ($urandom_range(99) >= stall_pct);
  end

  // Replies are sampled at the rising edge, before the block updates its outputs.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      shadow.check_reply(reply_t'(m_axis_tdata[1+VALUE_W+COUNT_W-1:0]));
    end
  end

  // Watchdog: ends the run when no item moves on either side for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("** lru_key_value_cache: FAILED **");
    $finish;
  end

  // Sends one request item, with random idle cycles ahead of it.
  task automatic send_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                              logic [VALUE_W-1:0] val);
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {val, key};
    do @(posedge clk_i); while (!s_axis_tready);
    shadow.note_request(op, key, val);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  // Mostly keys from a small pool so hits, refreshes and evictions are common.
  task automatic send_random_request();
    int unsigned      pick;
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    pick = $urandom_range(99);
    if (pick < 32)      op = OP_PUT;
    else if (pick < 56) op = OP_GET;
    else if (pick < 70) op = OP_EXISTS;
    else if (pick < 94) op = OP_ERASE;
    else if (pick < 96) op = OP_CLEAR;
    else                op = OP_W'($urandom_range(7, 5));
    if ($urandom_range(9) == 0) key = $urandom();
    else                        key = key_pool[$urandom_range(KEY_POOL-1)];
    send_request(op, key, $urandom());
  endtask

  // Capacity is written only while no reply is outstanding.
  task automatic write_capacity(logic [CAP_W-1:0] cap);
    while (shadow.pending() != 0) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = cap;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    shadow.set_capacity(cap);
  endtask

  initial begin
    logic [CAP_W-1:0] phase_caps [8];
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_GET;
    m_axis_tready = 1'b0;
    gap_pct       = 0;
    stall_pct     = 0;
    shadow        = new();
    for (int j = 0; j < KEY_POOL; j++) key_pool[j] = $urandom();
    // The first phase runs on the reset capacity; later ones write others, from zero to 31.
    phase_caps = '{CAP_RESET, 5'd0, 5'd1, 5'd31, 5'd3, 5'd16, 5'd2, 5'($urandom_range(31))};

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: key and value extremes, updates, misses and every opcode.
    send_request(OP_PUT, '0, '0);
    send_request(OP_PUT, '1, '1);
    send_request(OP_PUT, '0, 32'h5a5a_a5a5);
    send_request(OP_GET, '0, '1);
    send_request(OP_GET, '1, '0);
    send_request(OP_GET, key_pool[0], '1);
    send_request(OP_EXISTS, '1, '1);
    send_request(OP_EXISTS, key_pool[1], '0);
    send_request(OP_ERASE, '0, '1);
    send_request(OP_ERASE, '0, '0);
    send_request(OP_GET, '0, '0);
    send_request(OP_W'(5), '1, '1);
    send_request(OP_W'(6), '1, '1);
    send_request(OP_W'(7), '1, '1);
    send_request(OP_CLEAR, '1, '1);
    send_request(OP_GET, '1, '0);
    send_request(OP_EXISTS, '1, '0);
    send_request(OP_ERASE, '1, '0);

    // Random phases, each with its own capacity and idling pattern.
    for (int p = 0; p < 8; p++) begin
      if (p != 0) write_capacity(phase_caps[p]);
      case (p % 4)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 52; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 52; end
        default: begin gap_pct = 29; stall_pct = 29; end
      endcase
      repeat (ITEMS_PER_PHASE) send_random_request();
    end

    while (shadow.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (shadow.errors == 0) begin
      $display("** lru_key_value_cache: PASSED **");
    end else begin
      $display("** lru_key_value_cache: FAILED **");
    end
    $finish;
  end

endmodule
